[hdl/upg_pkg.sv]
package upg_pkg;

    // Number of decoded-result bundles buffered between the front and the back.
    localparam int UPG_QDEPTH = 4;

    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // Everything one request byte causes: up to three path bytes, then maybe a verdict.
    typedef struct packed {
        logic [1:0]      n_bytes;
        logic [2:0][7:0] bytes;
        logic            verdict;
    } upg_bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters of either case have 1..6 in the low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

[hdl/url_path_decode_and_guard.sv]
// Channel   Handshake           Fields
// input     push / full         in_byte, in_last
// result    empty / pop         kind, path_byte, rejected, is_root, out_last
//
// A request byte is taken every cycle while full is low; its decoded bytes and verdict are
// queued as one bundle. The back end sends one result per cycle while pop keeps its output
// register free, and a bundle leaves the queue only once its last result is sent.
// The queue holds QDEPTH bundles; full rises when it fills, during multi-result bursts
// or while pop is held low.
// Reset clears the escape state, the guard state, the queue and the output valid flag.
module url_path_decode_and_guard
    import upg_pkg::*;
#(
    parameter int QDEPTH = UPG_QDEPTH  // 2 or more
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       push,
    output logic       full,
    output logic       kind,
    output logic [7:0] path_byte,
    output logic       rejected,
    output logic       is_root,
    output logic       out_last,
    output logic       empty,
    input  logic       pop
);

    logic        q_full, q_empty, q_push, q_pop;
    upg_bundle_t q_wdata, q_rdata;

    upg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    upg_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    upg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .path_byte (path_byte),
        .rejected  (rejected),
        .is_root   (is_root),
        .out_last  (out_last)
    );

endmodule

[hdl/upg_front.sv]
module upg_front
    import upg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        push,
    output logic        full,
    input  logic        q_full,
    output logic        q_push,
    output upg_bundle_t q_data
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       in_query_reg, in_query_next;
    logic       accept;

    logic [2:0][7:0] blist;
    logic [1:0]      cnt;
    logic            verdict;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        in_query_next = in_query_reg;
        blist         = '0;
        cnt           = 2'd0;
        verdict       = 1'b0;

        if (in_query_reg)
        begin
            if (in_last)
            begin
                verdict       = 1'b1;
                in_query_next = 1'b0;
            end
        end
        else if (in_byte == CH_QUERY)
        begin
            // A pending escape is cut short and goes out literally.
            case (phase_reg)
                PH_PCT:
                begin
                    blist[cnt] = CH_PCT;
                    cnt        = cnt + 2'd1;
                end
                PH_DIGIT:
                begin
                    blist[cnt] = CH_PCT;
                    cnt        = cnt + 2'd1;
                    blist[cnt] = held_reg;
                    cnt        = cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
            phase_next    = PH_IDLE;
            held_next     = 8'd0;
            in_query_next = !in_last;
            verdict       = in_last;
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (is_hex(in_byte))
                    begin
                        held_next  = in_byte;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        blist[cnt] = CH_PCT;
                        cnt        = cnt + 2'd1;
                        if (in_byte == CH_PCT)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            blist[cnt] = in_byte;
                            cnt        = cnt + 2'd1;
                        end
                    end
                end
                PH_DIGIT:
                begin
                    phase_next = PH_IDLE;
                    held_next  = 8'd0;
                    if (is_hex(in_byte))
                    begin
                        blist[cnt] = {hex_val(held_reg), hex_val(in_byte)};
                        cnt        = cnt + 2'd1;
                    end
                    else
                    begin
                        blist[cnt] = CH_PCT;
                        cnt        = cnt + 2'd1;
                        blist[cnt] = held_reg;
                        cnt        = cnt + 2'd1;
                        if (in_byte == CH_PCT)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            blist[cnt] = in_byte;
                            cnt        = cnt + 2'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_byte == CH_PCT)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        blist[cnt] = in_byte;
                        cnt        = cnt + 2'd1;
                    end
                end
            endcase

            if (in_last)
            begin
                case (phase_next)
                    PH_PCT:
                    begin
                        blist[cnt] = CH_PCT;
                        cnt        = cnt + 2'd1;
                    end
                    PH_DIGIT:
                    begin
                        blist[cnt] = CH_PCT;
                        cnt        = cnt + 2'd1;
                        blist[cnt] = held_next;
                        cnt        = cnt + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                phase_next    = PH_IDLE;
                held_next     = 8'd0;
                in_query_next = 1'b0;
                verdict       = 1'b1;
            end
        end
    end

    assign q_push         = accept && ((cnt != 2'd0) || verdict);
    assign q_data.n_bytes = cnt;
    assign q_data.bytes   = blist;
    assign q_data.verdict = verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            held_reg     <= 8'd0;
            in_query_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            in_query_reg <= in_query_next;
        end
    end

    a_query_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        in_query_reg |-> (phase_reg == PH_IDLE))
        else $error("escape pending while the query part is dropped");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (phase_reg == PH_IDLE) && !in_query_reg && (held_reg == 8'd0))
        else $error("front state not cleared after the final byte");

endmodule

[hdl/upg_fifo.sv]
module upg_fifo
    import upg_pkg::*;
#(
    parameter int DEPTH = UPG_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  upg_bundle_t wdata,
    output logic        full,
    input  logic        rd,
    output upg_bundle_t rdata,
    output logic        empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upg_bundle_t     mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : (p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above its depth");

    a_no_lost_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("bundle written into a full queue");

endmodule

[hdl/upg_back.sv]
module upg_back
    import upg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  upg_bundle_t q_data,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  path_byte,
    output logic        rejected,
    output logic        is_root,
    output logic        out_last
);

    logic [1:0] slot_reg;
    logic [1:0] count_reg;
    logic       prev_dot_reg;
    logic       bad_reg;
    logic       out_valid_reg;
    logic       kind_reg, rejected_reg, is_root_reg, out_last_reg;
    logic [7:0] byte_reg;

    logic [2:0] total;
    logic       is_byte;
    logic       bundle_done;
    logic       out_free;
    logic       fire;
    logic [7:0] cur_b;
    logic       bad_next;

    assign total       = {1'b0, q_data.n_bytes} + {2'b00, q_data.verdict};
    assign is_byte     = (slot_reg < q_data.n_bytes);
    assign bundle_done = (({1'b0, slot_reg} + 3'd1) == total);
    assign out_free    = !out_valid_reg || pop;
    assign fire        = !q_empty && out_free;
    assign q_pop       = fire && bundle_done;

    always_comb
    begin
        case (slot_reg)
            2'd0:    cur_b = q_data.bytes[0];
            2'd1:    cur_b = q_data.bytes[1];
            2'd2:    cur_b = q_data.bytes[2];
            default: cur_b = 8'd0;
        endcase
    end

    assign bad_next = bad_reg ||
                      ((count_reg == 2'd0) && (cur_b != CH_SLASH)) ||
                      ((cur_b == CH_DOT) && prev_dot_reg) ||
                      (cur_b == CH_BSLASH) || (cur_b == CH_NUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            count_reg     <= 2'd0;
            prev_dot_reg  <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= bundle_done ? 2'd0 : (slot_reg + 2'd1);
                if (is_byte)
                begin
                    bad_reg      <= bad_next;
                    prev_dot_reg <= (cur_b == CH_DOT);
                    if (count_reg != 2'd2)
                    begin
                        count_reg <= count_reg + 2'd1;
                    end
                end
                else
                begin
                    // The verdict closes the request; the guard starts over.
                    bad_reg      <= 1'b0;
                    prev_dot_reg <= 1'b0;
                    count_reg    <= 2'd0;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg     <= !is_byte;
            byte_reg     <= is_byte ? cur_b : 8'd0;
            rejected_reg <= !is_byte && ((count_reg == 2'd0) || bad_reg);
            is_root_reg  <= !is_byte && (count_reg == 2'd1) && !bad_reg;
            out_last_reg <= !is_byte;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = kind_reg;
    assign path_byte = byte_reg;
    assign rejected  = rejected_reg;
    assign is_root   = is_root_reg;
    assign out_last  = out_last_reg;

    a_slot_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> ({1'b0, slot_reg} < total))
        else $error("result slot beyond the head bundle");

    a_verdict_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_byte) |=> (count_reg == 2'd0) && !bad_reg && !prev_dot_reg)
        else $error("guard state survives a verdict");

    a_root_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_root_reg) |-> (kind_reg && !rejected_reg))
        else $error("root flag on a rejected or non-verdict result");

endmodule
